### design/nilj_pkg.sv
// Shared constants and types of the nearest in-limit joint solution selector.
`default_nettype none

package nilj_pkg;

   localparam int NUM_JOINTS    = 4;
   localparam int NUM_LIMITS    = 2 * NUM_JOINTS;
   localparam int CSR_INDEX_W   = 4;
   localparam int IDX_W         = 8;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LEVEL_W = $clog2(QUEUE_DEPTH + 3);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_J1_LOW  = 4'd0,
      REG_J1_HIGH = 4'd1,
      REG_J2_LOW  = 4'd2,
      REG_J2_HIGH = 4'd3,
      REG_J3_LOW  = 4'd4,
      REG_J3_HIGH = 4'd5,
      REG_J4_LOW  = 4'd6,
      REG_J4_HIGH = 4'd7
   } reg_index_type;

   localparam int LIMIT_RESET [NUM_LIMITS] = '{
      -2400, 2400, -1600, 1600, -3200, -1600, -2560, 2560
   };

endpackage

`default_nettype wire

### design/nilj_req_if.sv
// Candidate input channel: valid, ready and one candidate with the current position.
`default_nettype none

interface nilj_req_if #(
   parameter int JOINT_WIDTH = 20
);
   logic                          valid;
   logic                          ready;
   logic signed [JOINT_WIDTH-1:0] cand_j1;
   logic signed [JOINT_WIDTH-1:0] cand_j2;
   logic signed [JOINT_WIDTH-1:0] cand_j3;
   logic signed [JOINT_WIDTH-1:0] cand_j4;
   logic signed [JOINT_WIDTH-1:0] now_j1;
   logic signed [JOINT_WIDTH-1:0] now_j2;
   logic signed [JOINT_WIDTH-1:0] now_j3;
   logic signed [JOINT_WIDTH-1:0] now_j4;
   logic                          last_cand;

   modport source (
      output valid, cand_j1, cand_j2, cand_j3, cand_j4,
             now_j1, now_j2, now_j3, now_j4, last_cand,
      input  ready
   );

   modport sink (
      input  valid, cand_j1, cand_j2, cand_j3, cand_j4,
             now_j1, now_j2, now_j3, now_j4, last_cand,
      output ready
   );
endinterface

`default_nettype wire

### design/nilj_rsp_if.sv
// Result channel: valid, ready and the chosen joint solution.
`default_nettype none

interface nilj_rsp_if #(
   parameter int JOINT_WIDTH = 20
);
   logic                          valid;
   logic                          ready;
   logic signed [JOINT_WIDTH-1:0] pick_j1;
   logic signed [JOINT_WIDTH-1:0] pick_j2;
   logic signed [JOINT_WIDTH-1:0] pick_j3;
   logic signed [JOINT_WIDTH-1:0] pick_j4;
   logic [7:0]                    pick_index;
   logic                          was_in_range;

   modport source (
      output valid, pick_j1, pick_j2, pick_j3, pick_j4, pick_index, was_in_range,
      input  ready
   );

   modport sink (
      input  valid, pick_j1, pick_j2, pick_j3, pick_j4, pick_index, was_in_range,
      output ready
   );
endinterface

`default_nettype wire

### design/nilj_csr_if.sv
// Configuration write channel: valid, ready, register index and write data.
`default_nettype none

interface nilj_csr_if #(
   parameter int JOINT_WIDTH = 20
);
   logic                   valid;
   logic                   ready;
   logic [3:0]             index;
   logic [JOINT_WIDTH-1:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );

   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

`default_nettype wire

### design/nilj_front.sv
// Front end: accepts candidates, checks limits, precomputes clamps and the squared distance.
`default_nettype none

module nilj_front import nilj_pkg::*; #(
   parameter  int JOINT_WIDTH = 20,
   localparam int SQ_W        = 2 * JOINT_WIDTH + 1,
   localparam int DIST_W      = 2 * JOINT_WIDTH + 3,
   localparam int ENTRY_W     = 2 + DIST_W + 2 * NUM_JOINTS * JOINT_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   nilj_req_if.sink                      req,
   input  logic signed [JOINT_WIDTH-1:0] lim_low  [NUM_JOINTS],
   input  logic signed [JOINT_WIDTH-1:0] lim_high [NUM_JOINTS],
   input  logic [QUEUE_LEVEL_W-1:0]      q_level,
   output logic                          push,
   output logic [ENTRY_W-1:0]            push_data
);

   typedef logic signed [JOINT_WIDTH-1:0] joint_type;

   typedef struct packed {
      logic                                    last;
      logic                                    inr;
      logic [DIST_W-1:0]                       sq_sum;
      logic [NUM_JOINTS-1:0][JOINT_WIDTH-1:0]  cand;
      logic [NUM_JOINTS-1:0][JOINT_WIDTH-1:0]  clamp;
   } entry_type;

   function automatic logic [JOINT_WIDTH:0] abs_diff(input joint_type a, input joint_type b);
      logic [JOINT_WIDTH:0] d;
      d = {a[JOINT_WIDTH-1], a} - {b[JOINT_WIDTH-1], b};
      return d[JOINT_WIDTH] ? (~d + 1'b1) : d;
   endfunction

   joint_type                              cand [NUM_JOINTS];
   joint_type                              now  [NUM_JOINTS];
   logic [NUM_JOINTS-1:0]                  outside;
   logic [JOINT_WIDTH:0]                   mag_lo [NUM_JOINTS];
   logic [JOINT_WIDTH:0]                   mag_hi [NUM_JOINTS];
   logic [2*JOINT_WIDTH+1:0]               prod   [NUM_JOINTS];
   logic [QUEUE_LEVEL_W-1:0]               level;
   logic                                   accept;
   entry_type                              entry;

   logic                                   s1_valid_ff, s1_valid_in;
   logic                                   s1_last_ff,  s1_last_in;
   logic                                   s1_inr_ff,   s1_inr_in;
   logic [NUM_JOINTS-1:0][JOINT_WIDTH-1:0] s1_cand_ff,  s1_cand_in;
   logic [NUM_JOINTS-1:0][JOINT_WIDTH-1:0] s1_clamp_ff, s1_clamp_in;
   logic [NUM_JOINTS-1:0][JOINT_WIDTH:0]   s1_mag_ff,   s1_mag_in;

   logic                                   s2_valid_ff, s2_valid_in;
   logic                                   s2_last_ff,  s2_last_in;
   logic                                   s2_inr_ff,   s2_inr_in;
   logic [NUM_JOINTS-1:0][JOINT_WIDTH-1:0] s2_cand_ff,  s2_cand_in;
   logic [NUM_JOINTS-1:0][JOINT_WIDTH-1:0] s2_clamp_ff, s2_clamp_in;
   logic [NUM_JOINTS-1:0][SQ_W-1:0]        s2_sq_ff,    s2_sq_in;

   // Every item in the pipeline already holds a queue slot, so the stages never stall.
   assign level     = q_level + QUEUE_LEVEL_W'(s1_valid_ff) + QUEUE_LEVEL_W'(s2_valid_ff);
   assign req.ready = (level < QUEUE_LEVEL_W'(QUEUE_DEPTH));
   assign accept    = req.valid && req.ready;

   assign cand[0] = req.cand_j1;
   assign cand[1] = req.cand_j2;
   assign cand[2] = req.cand_j3;
   assign cand[3] = req.cand_j4;
   assign now[0]  = req.now_j1;
   assign now[1]  = req.now_j2;
   assign now[2]  = req.now_j3;
   assign now[3]  = req.now_j4;

   always_comb begin
      s1_valid_in = accept;
      s1_last_in  = req.last_cand;
      for (int k = 0; k < NUM_JOINTS; k++) begin
         outside[k]     = (cand[k] < lim_low[k]) || (cand[k] > lim_high[k]);
         mag_lo[k]      = abs_diff(cand[k], lim_low[k]);
         mag_hi[k]      = abs_diff(cand[k], lim_high[k]);
         s1_cand_in[k]  = cand[k];
         s1_mag_in[k]   = abs_diff(cand[k], now[k]);
         if (!outside[k]) begin
            s1_clamp_in[k] = cand[k];
         end else if (mag_lo[k] < mag_hi[k]) begin
            s1_clamp_in[k] = lim_low[k];
         end else begin
            s1_clamp_in[k] = lim_high[k];
         end
      end
      s1_inr_in = ~|outside;
   end

   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_last_in  = s1_last_ff;
      s2_inr_in   = s1_inr_ff;
      s2_cand_in  = s1_cand_ff;
      s2_clamp_in = s1_clamp_ff;
      for (int k = 0; k < NUM_JOINTS; k++) begin
         prod[k]     = (2*JOINT_WIDTH+2)'(s1_mag_ff[k]) * (2*JOINT_WIDTH+2)'(s1_mag_ff[k]);
         s2_sq_in[k] = prod[k][SQ_W-1:0];
      end
   end

   always_comb begin
      entry.last   = s2_last_ff;
      entry.inr    = s2_inr_ff;
      entry.sq_sum = (DIST_W'(s2_sq_ff[0]) + DIST_W'(s2_sq_ff[1]))
                   + (DIST_W'(s2_sq_ff[2]) + DIST_W'(s2_sq_ff[3]));
      entry.cand   = s2_cand_ff;
      entry.clamp  = s2_clamp_ff;
   end

   assign push      = s2_valid_ff;
   assign push_data = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff  <= s1_last_in;
      s1_inr_ff   <= s1_inr_in;
      s1_cand_ff  <= s1_cand_in;
      s1_clamp_ff <= s1_clamp_in;
      s1_mag_ff   <= s1_mag_in;
      s2_last_ff  <= s2_last_in;
      s2_inr_ff   <= s2_inr_in;
      s2_cand_ff  <= s2_cand_in;
      s2_clamp_ff <= s2_clamp_in;
      s2_sq_ff    <= s2_sq_in;
   end

endmodule

`default_nettype wire

### design/nilj_queue.sv
// Short queue that decouples the front end from the selection back end.
`default_nettype none

module nilj_queue import nilj_pkg::*; #(
   parameter int WIDTH = 126
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [WIDTH-1:0]         push_data,
   input  logic                     pop,
   output logic [WIDTH-1:0]         pop_data,
   output logic                     not_empty,
   output logic [QUEUE_LEVEL_W-1:0] level
);

   logic [WIDTH-1:0]         mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_LEVEL_W-1:0] count_ff,  count_in;

   assign pop_data  = mem[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign level     = count_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_LEVEL_W'(push) - QUEUE_LEVEL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != QUEUE_LEVEL_W'(QUEUE_DEPTH)))
      else $error("Queue written while full.");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("Queue read while empty.");

endmodule

`default_nettype wire

### design/nilj_back.sv
// Back end: keeps the running nearest candidates and registers the result of each run.
`default_nettype none

module nilj_back import nilj_pkg::*; #(
   parameter  int MAX_CANDIDATES = 256,
   parameter  int JOINT_WIDTH    = 20,
   localparam int DIST_W         = 2 * JOINT_WIDTH + 3,
   localparam int ENTRY_W        = 2 + DIST_W + 2 * NUM_JOINTS * JOINT_WIDTH,
   localparam int IDX_CAP        = (MAX_CANDIDATES - 1 > 255) ? 255 : MAX_CANDIDATES - 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  logic [ENTRY_W-1:0] q_data,
   output logic               pop,
   nilj_rsp_if.source         rsp
);

   typedef struct packed {
      logic                                    last;
      logic                                    inr;
      logic [DIST_W-1:0]                       sq_sum;
      logic [NUM_JOINTS-1:0][JOINT_WIDTH-1:0]  cand;
      logic [NUM_JOINTS-1:0][JOINT_WIDTH-1:0]  clamp;
   } entry_type;

   entry_type                              head;
   logic                                   out_free;
   logic                                   upd_all;
   logic                                   upd_in;
   logic                                   any_next;

   logic [IDX_W-1:0]                       cand_count_ff, cand_count_in;
   logic                                   any_in_ff,     any_in_in;
   logic [DIST_W-1:0]                      best_in_dist_ff,    best_in_dist_in;
   logic [NUM_JOINTS-1:0][JOINT_WIDTH-1:0] best_in_joints_ff,  best_in_joints_in;
   logic [IDX_W-1:0]                       best_in_index_ff,   best_in_index_in;
   logic [DIST_W-1:0]                      best_all_dist_ff,   best_all_dist_in;
   logic [NUM_JOINTS-1:0][JOINT_WIDTH-1:0] best_all_joints_ff, best_all_joints_in;
   logic [IDX_W-1:0]                       best_all_index_ff,  best_all_index_in;

   logic                                   rsp_valid_ff,  rsp_valid_in;
   logic [NUM_JOINTS-1:0][JOINT_WIDTH-1:0] rsp_joints_ff, rsp_joints_in;
   logic [IDX_W-1:0]                       rsp_index_ff,  rsp_index_in;
   logic                                   rsp_inr_ff,    rsp_inr_in;

   assign head     = q_data;
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign pop      = q_valid && (!head.last || out_free);

   always_comb begin
      upd_all  = (cand_count_ff == '0) || (head.sq_sum < best_all_dist_ff);
      upd_in   = head.inr && (!any_in_ff || (head.sq_sum < best_in_dist_ff));
      any_next = any_in_ff || head.inr;

      best_all_dist_in   = upd_all ? head.sq_sum   : best_all_dist_ff;
      best_all_joints_in = upd_all ? head.clamp    : best_all_joints_ff;
      best_all_index_in  = upd_all ? cand_count_ff : best_all_index_ff;
      best_in_dist_in    = upd_in  ? head.sq_sum   : best_in_dist_ff;
      best_in_joints_in  = upd_in  ? head.cand     : best_in_joints_ff;
      best_in_index_in   = upd_in  ? cand_count_ff : best_in_index_ff;

      cand_count_in = cand_count_ff;
      any_in_in     = any_in_ff;
      if (pop) begin
         if (head.last) begin
            cand_count_in = '0;
            any_in_in     = 1'b0;
         end else begin
            any_in_in = any_next;
            if (cand_count_ff < IDX_W'(IDX_CAP)) begin
               cand_count_in = cand_count_ff + 1'b1;
            end
         end
      end

      rsp_joints_in = any_next ? best_in_joints_in : best_all_joints_in;
      rsp_index_in  = any_next ? best_in_index_in  : best_all_index_in;
      rsp_inr_in    = any_next;

      if (pop && head.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_count_ff <= '0;
         any_in_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cand_count_ff <= cand_count_in;
         any_in_ff     <= any_in_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         best_all_dist_ff   <= best_all_dist_in;
         best_all_joints_ff <= best_all_joints_in;
         best_all_index_ff  <= best_all_index_in;
         best_in_dist_ff    <= best_in_dist_in;
         best_in_joints_ff  <= best_in_joints_in;
         best_in_index_ff   <= best_in_index_in;
      end
      if (pop && head.last) begin
         rsp_joints_ff <= rsp_joints_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_inr_ff    <= rsp_inr_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.pick_j1      = rsp_joints_ff[0];
   assign rsp.pick_j2      = rsp_joints_ff[1];
   assign rsp.pick_j3      = rsp_joints_ff[2];
   assign rsp.pick_j4      = rsp_joints_ff[3];
   assign rsp.pick_index   = rsp_index_ff;
   assign rsp.was_in_range = rsp_inr_ff;

   a_run_cleared: assert property (@(posedge clock) disable iff (reset)
      (pop && head.last) |=> (rsp_valid_ff && (cand_count_ff == '0) && !any_in_ff))
      else $error("Run state not cleared after the last candidate.");

   a_in_range_needs_candidate: assert property (@(posedge clock) disable iff (reset)
      any_in_ff |-> (cand_count_ff != '0))
      else $error("In-range winner recorded without any candidate.");

   a_last_waits_for_slot: assert property (@(posedge clock) disable iff (reset)
      (q_valid && head.last && rsp_valid_ff && !rsp.ready) |=> rsp_valid_ff)
      else $error("Result lost while a further run ended.");

endmodule

`default_nettype wire

### design/nearest_in_limit_joint_solution.sv
// Top level of the nearest in-limit joint solution selector with its limit registers.
// A run's result is registered after its last candidate passes the front end and queue.
// Throughput: one candidate per cycle while the queue has room, set by the two-stage
// front end and the compare and update in the back end.
// A waiting result does not hold up candidates until the four-entry queue fills.
// Reset clears the run state, the queue and the result, and loads the default limits.
`default_nettype none

module nearest_in_limit_joint_solution import nilj_pkg::*; #(
   parameter int MAX_CANDIDATES = 256,
   parameter int JOINT_WIDTH    = 20
) (
   input  logic       clock,
   input  logic       reset,
   nilj_req_if.sink   req_ch,
   nilj_rsp_if.source rsp_ch,
   nilj_csr_if.sink   csr_ch
);

   localparam int DIST_W  = 2 * JOINT_WIDTH + 3;
   localparam int ENTRY_W = 2 + DIST_W + 2 * NUM_JOINTS * JOINT_WIDTH;

   logic signed [JOINT_WIDTH-1:0] lim_ff [NUM_LIMITS];
   logic signed [JOINT_WIDTH-1:0] lim_in [NUM_LIMITS];
   logic signed [JOINT_WIDTH-1:0] lim_low  [NUM_JOINTS];
   logic signed [JOINT_WIDTH-1:0] lim_high [NUM_JOINTS];

   logic                     push;
   logic [ENTRY_W-1:0]       push_data;
   logic                     pop;
   logic [ENTRY_W-1:0]       pop_data;
   logic                     not_empty;
   logic [QUEUE_LEVEL_W-1:0] q_level;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      lim_in = lim_ff;
      if (csr_ch.valid) begin
         unique case (reg_index_type'(csr_ch.index))
            REG_J1_LOW:  lim_in[0] = csr_ch.data;
            REG_J1_HIGH: lim_in[1] = csr_ch.data;
            REG_J2_LOW:  lim_in[2] = csr_ch.data;
            REG_J2_HIGH: lim_in[3] = csr_ch.data;
            REG_J3_LOW:  lim_in[4] = csr_ch.data;
            REG_J3_HIGH: lim_in[5] = csr_ch.data;
            REG_J4_LOW:  lim_in[6] = csr_ch.data;
            REG_J4_HIGH: lim_in[7] = csr_ch.data;
            default: ;
         endcase
      end
      for (int k = 0; k < NUM_JOINTS; k++) begin
         lim_low[k]  = lim_ff[2*k];
         lim_high[k] = lim_ff[2*k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LIMITS; i++) begin
            lim_ff[i] <= JOINT_WIDTH'(LIMIT_RESET[i]);
         end
      end else begin
         lim_ff <= lim_in;
      end
   end

   nilj_front #(
      .JOINT_WIDTH (JOINT_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .lim_low   (lim_low),
      .lim_high  (lim_high),
      .q_level   (q_level),
      .push      (push),
      .push_data (push_data)
   );

   nilj_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (not_empty),
      .level     (q_level)
   );

   nilj_back #(
      .MAX_CANDIDATES (MAX_CANDIDATES),
      .JOINT_WIDTH    (JOINT_WIDTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (not_empty),
      .q_data  (pop_data),
      .pop     (pop),
      .rsp     (rsp_ch)
   );

endmodule

`default_nettype wire

### sim/nilj_check_pkg.sv
// Item types and the scoreboard that predicts and checks the selector's picks.
package nilj_check_pkg;

   import nilj_pkg::*;

   localparam int JW        = 20;
   localparam int RUN_LIMIT = 256;
   localparam int INDEX_CAP = (RUN_LIMIT - 1 > 255) ? 255 : RUN_LIMIT - 1;

   typedef logic signed [JW-1:0] joint_t;

   typedef struct packed {
      joint_t [NUM_JOINTS-1:0] cand;
      joint_t [NUM_JOINTS-1:0] now;
      logic                    last;
   } candidate_t;

   typedef struct packed {
      joint_t [NUM_JOINTS-1:0] joints;
      logic [IDX_W-1:0]        index;
      logic                    in_range;
   } pick_t;

   typedef longint limit_set_t [NUM_JOINTS];

   class pick_scoreboard;
      longint                  low_lim [NUM_JOINTS];
      longint                  high_lim [NUM_JOINTS];
      int                      failures;
      int unsigned             run_count;
      bit                      have_in;
      longint                  in_dist;
      longint                  all_dist;
      joint_t [NUM_JOINTS-1:0] in_joints;
      joint_t [NUM_JOINTS-1:0] all_joints;
      logic [IDX_W-1:0]        in_index;
      logic [IDX_W-1:0]        all_index;
      pick_t                   expected_q [$];

      function new();
         for (int k = 0; k < NUM_JOINTS; k++) begin
            low_lim[k]  = LIMIT_RESET[2*k];
            high_lim[k] = LIMIT_RESET[2*k+1];
         end
         failures = 0;
         clear_run();
      endfunction

      function void clear_run();
         run_count  = 0;
         have_in    = 1'b0;
         in_dist    = 0;
         all_dist   = 0;
         in_joints  = '0;
         all_joints = '0;
         in_index   = '0;
         all_index  = '0;
      endfunction

      function longint magnitude(longint x);
         return (x < 0) ? -x : x;
      endfunction

      function void set_limit(logic [CSR_INDEX_W-1:0] index, joint_t value);
         if (index < NUM_LIMITS) begin
            if (index[0]) begin
               high_lim[index >> 1] = value;
            end else begin
               low_lim[index >> 1] = value;
            end
         end
      endfunction

      function void note_candidate(candidate_t item);
         longint sq_sum;
         longint v;
         longint lo;
         longint hi;
         joint_t cj;
         joint_t nj;
         bit     fits;
         pick_t  want;
         sq_sum = 0;
         fits   = 1'b1;
         for (int k = 0; k < NUM_JOINTS; k++) begin
            cj = item.cand[k];
            nj = item.now[k];
            v  = cj;
            if (v < low_lim[k] || v > high_lim[k]) begin
               fits = 1'b0;
            end
            sq_sum += (v - longint'(nj)) * (v - longint'(nj));
         end
         if (run_count == 0 || sq_sum < all_dist) begin
            all_dist   = sq_sum;
            all_index  = IDX_W'(run_count);
            all_joints = item.cand;
         end
         if (fits && (!have_in || sq_sum < in_dist)) begin
            have_in   = 1'b1;
            in_dist   = sq_sum;
            in_index  = IDX_W'(run_count);
            in_joints = item.cand;
         end
         if (run_count < INDEX_CAP) begin
            run_count++;
         end
         if (item.last) begin
            for (int k = 0; k < NUM_JOINTS; k++) begin
               if (have_in) begin
                  want.joints[k] = in_joints[k];
               end else begin
                  cj = all_joints[k];
                  v  = cj;
                  lo = low_lim[k];
                  hi = high_lim[k];
                  if (v < lo || v > hi) begin
                     v = (magnitude(v - lo) < magnitude(v - hi)) ? lo : hi;
                  end
                  want.joints[k] = joint_t'(v);
               end
            end
            want.index    = have_in ? in_index : all_index;
            want.in_range = have_in;
            expected_q.push_back(want);
            clear_run();
         end
      endfunction

      function void check_pick(pick_t got);
         pick_t  want;
         joint_t w;
         joint_t g;
         if (expected_q.size() == 0) begin
            $error("result with no pick expected: pick_index %0d", got.index);
            failures++;
            return;
         end
         want = expected_q.pop_front();
         for (int k = 0; k < NUM_JOINTS; k++) begin
            w = want.joints[k];
            g = got.joints[k];
            if (g !== w) begin
               $error("pick_j%0d: expected %0d, got %0d", k + 1, w, g);
               failures++;
            end
         end
         if (got.index !== want.index) begin
            $error("pick_index: expected %0d, got %0d", want.index, got.index);
            failures++;
         end
         if (got.in_range !== want.in_range) begin
            $error("was_in_range: expected %0d, got %0d", want.in_range, got.in_range);
            failures++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

endpackage

### sim/testbench.sv
// Testbench of the nearest in-limit joint solution selector: drives candidate runs and limits.
module testbench;

   import nilj_pkg::*;
   import nilj_check_pkg::*;

   localparam int     CYCLE_LIMIT   = 200000;
   localparam int     DRAIN_CYCLES  = 12;
   localparam int     SETTLE_CYCLES = 8;
   localparam int     STALL_PERCENT = 18;
   localparam longint JOINT_MIN     = -524288;
   localparam longint JOINT_MAX     = 524287;
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED = 4'hB;

   logic           clock;
   logic           reset;
   bit             calm;
   int             cycle_count;
   pick_scoreboard board;
   candidate_t     prev_item;

   nilj_req_if #(.JOINT_WIDTH(JW)) req_ch ();
   nilj_rsp_if #(.JOINT_WIDTH(JW)) rsp_ch ();
   nilj_csr_if #(.JOINT_WIDTH(JW)) csr_ch ();

   nearest_in_limit_joint_solution #(
      .MAX_CANDIDATES(RUN_LIMIT),
      .JOINT_WIDTH(JW)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   always #6 clock = ~clock;

   always @(negedge clock) begin
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= STALL_PERCENT);
   end

   always @(posedge clock) begin : take_pick
      pick_t got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.joints[0] = rsp_ch.pick_j1;
         got.joints[1] = rsp_ch.pick_j2;
         got.joints[2] = rsp_ch.pick_j3;
         got.joints[3] = rsp_ch.pick_j4;
         got.index     = rsp_ch.pick_index;
         got.in_range  = rsp_ch.was_in_range;
         board.check_pick(got);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_candidate(candidate_t item);
      while (!calm && $urandom_range(0, 99) < STALL_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.cand_j1   <= item.cand[0];
      req_ch.cand_j2   <= item.cand[1];
      req_ch.cand_j3   <= item.cand[2];
      req_ch.cand_j4   <= item.cand[3];
      req_ch.now_j1    <= item.now[0];
      req_ch.now_j2    <= item.now[1];
      req_ch.now_j3    <= item.now[2];
      req_ch.now_j4    <= item.now[3];
      req_ch.last_cand <= item.last;
      do @(posedge clock); while (!req_ch.ready);
      board.note_candidate(item);
      prev_item = item;
      @(negedge clock);
   endtask

   task automatic send_fixed(longint c1, longint c2, longint c3, longint c4,
                             longint n1, longint n2, longint n3, longint n4, bit last);
      candidate_t c;
      c.cand = {joint_t'(c4), joint_t'(c3), joint_t'(c2), joint_t'(c1)};
      c.now  = {joint_t'(n4), joint_t'(n3), joint_t'(n2), joint_t'(n1)};
      c.last = last;
      send_candidate(c);
   endtask

   function automatic joint_t pick_near(longint lo, longint hi);
      longint a;
      longint b;
      longint v;
      joint_t r;
      a = (lo < hi) ? lo : hi;
      b = (lo < hi) ? hi : lo;
      r = joint_t'($urandom);
      case ($urandom_range(0, 12))
         0, 1, 2: v = r;
         8:       v = lo;
         9:       v = hi;
         10:      v = lo - 1;
         11:      v = hi + 1;
         12:      v = (lo + hi) / 2;
         default: v = a + $urandom_range(0, int'(b - a));
      endcase
      return joint_t'(v);
   endfunction

   task automatic send_run(int length);
      candidate_t c;
      for (int i = 0; i < length; i++) begin
         for (int k = 0; k < NUM_JOINTS; k++) begin
            c.cand[k] = pick_near(board.low_lim[k], board.high_lim[k]);
            c.now[k]  = ($urandom_range(0, 3) == 0) ? joint_t'($urandom)
                        : pick_near(board.low_lim[k], board.high_lim[k]);
         end
         // A repeated candidate gives an exact tie in distance.
         if (i > 0 && $urandom_range(0, 9) == 0) begin
            c.cand = prev_item.cand;
            c.now  = prev_item.now;
         end
         c.last = (i == length - 1);
         send_candidate(c);
      end
   endtask

   task automatic random_runs(int items, int longest);
      int len;
      while (items > 0) begin
         len = $urandom_range(1, longest);
         if (len > items) begin
            len = items;
         end
         send_run(len);
         items -= len;
      end
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (board.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(logic [CSR_INDEX_W-1:0] index, joint_t value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      board.set_limit(index, value);
      @(negedge clock);
   endtask

   task automatic program_limits(limit_set_t lo, limit_set_t hi, bit add_unmapped);
      for (int k = 0; k < NUM_JOINTS; k++) begin
         write_limit(reg_index_type'(2 * k), joint_t'(lo[k]));
         write_limit(reg_index_type'(2 * k + 1), joint_t'(hi[k]));
      end
      if (add_unmapped) begin
         write_limit(REG_UNMAPPED, joint_t'($urandom));
      end
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      limit_set_t lo;
      limit_set_t hi;
      joint_t     base;
      longint     swap;
      clock            = 1'b0;
      reset            = 1'b1;
      calm             = 1'b0;
      board            = new();
      prev_item        = '0;
      req_ch.valid     = 1'b0;
      req_ch.cand_j1   = '0;
      req_ch.cand_j2   = '0;
      req_ch.cand_j3   = '0;
      req_ch.cand_j4   = '0;
      req_ch.now_j1    = '0;
      req_ch.now_j2    = '0;
      req_ch.now_j3    = '0;
      req_ch.now_j4    = '0;
      req_ch.last_cand = 1'b0;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = '0;
      csr_ch.data      = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_fixed(0, 0, -2000, 0, 0, 0, -2000, 0, 1);
      send_fixed(300, 0, -1700, 0, 0, 0, -1700, 0, 0);
      send_fixed(0, 0, -1550, 0, 0, 0, -1700, 0, 0);
      send_fixed(0, 300, -1700, 0, 0, 0, -1700, 0, 1);
      send_fixed(3000, -2000, 0, 3000, 0, 0, 0, 0, 0);
      send_fixed(2500, 0, -1000, 0, 0, 0, 0, 0, 0);
      send_fixed(-2500, 0, 0, 0, 0, 0, 0, 0, 0);
      send_fixed(0, 1700, 0, 0, 0, 0, 0, 0, 1);
      send_fixed(JOINT_MAX, JOINT_MIN, JOINT_MAX, JOINT_MIN,
                 JOINT_MIN, JOINT_MAX, JOINT_MIN, JOINT_MAX, 0);
      send_fixed(JOINT_MIN, JOINT_MAX, JOINT_MIN, JOINT_MAX,
                 JOINT_MAX, JOINT_MIN, JOINT_MAX, JOINT_MIN, 1);
      send_fixed(2500, 0, -2000, 0, 0, 0, -2000, 0, 0);
      send_fixed(-2500, 0, -2000, 0, 0, 0, -2000, 0, 1);
      send_fixed(-2400, 1600, -3200, 2560, -2400, 1600, -3200, 2560, 0);
      send_fixed(2400, -1600, -1600, -2560, 0, 0, 0, 0, 1);
      random_runs(40, 8);

      settle();
      lo = '{JOINT_MIN, JOINT_MIN, JOINT_MIN, JOINT_MIN};
      hi = '{JOINT_MAX, JOINT_MAX, JOINT_MAX, JOINT_MAX};
      program_limits(lo, hi, 1'b0);
      calm = 1'b1;
      random_runs(80, 6);
      calm = 1'b0;

      settle();
      lo = '{160, 100, -150, 150};
      hi = '{-160, -100, -200, -150};
      program_limits(lo, hi, 1'b0);
      send_fixed(0, 0, -175, 0, 5, 5, 5, 5, 1);
      random_runs(40, 5);

      settle();
      lo = '{JOINT_MAX, -100, 0, JOINT_MIN};
      hi = '{JOINT_MIN, -100, 0, JOINT_MIN};
      program_limits(lo, hi, 1'b0);
      random_runs(40, 6);

      settle();
      for (int k = 0; k < NUM_JOINTS; k++) begin
         base  = joint_t'($urandom);
         lo[k] = base;
         hi[k] = lo[k] + $urandom_range(0, 30000);
         if (hi[k] > JOINT_MAX) begin
            hi[k] = JOINT_MAX;
         end
         if ($urandom_range(0, 3) == 0) begin
            swap  = lo[k];
            lo[k] = hi[k];
            hi[k] = swap;
         end
      end
      program_limits(lo, hi, 1'b1);
      random_runs(40, 8);
      settle();
      random_runs(40, 8);

      settle();
      for (int k = 0; k < NUM_JOINTS; k++) begin
         lo[k] = LIMIT_RESET[2*k];
         hi[k] = LIMIT_RESET[2*k+1];
      end
      program_limits(lo, hi, 1'b0);
      // A run longer than the index range makes the candidate count saturate.
      send_run(260);
      random_runs(40, 8);

      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### files.f
design/nilj_pkg.sv
design/nilj_req_if.sv
design/nilj_rsp_if.sv
design/nilj_csr_if.sv
design/nilj_front.sv
design/nilj_queue.sv
design/nilj_back.sv
design/nearest_in_limit_joint_solution.sv
sim/nilj_check_pkg.sv
sim/testbench.sv
